### hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the software timer slot table.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int SLOTS   = 16;
   localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int OP_W     = 3;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int TPS_W    = 16;

   localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

   localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OP_W-1:0] OP_START_PER  = 3'd1;
   localparam logic [OP_W-1:0] OP_START_ONCE = 3'd2;
   localparam logic [OP_W-1:0] OP_CANCEL     = 3'd3;
   localparam logic [OP_W-1:0] OP_SET_SEC    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FIRED    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SCAN_END = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request beat
      logic exec_op;    // run a non-tick op and emit its result
      logic advance;    // tick: advance counters, restart scan
      logic scan_step;  // handle current slot, move to next
      logic emit_end;   // emit end-of-scan result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic is_tick;
      logic fire;
      logic scan_done;
   } sts_type;

endpackage

### hw/rtl/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: accepts a request, runs it, walks the slots on a tick.
// ----------------------------------------------------------------------------
module stt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stt_pkg::sts_type sts,
   output stt_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_END  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      step;

   // a firing slot has to wait for room in the output register
   assign step = !sts.fire || sts.out_free;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.is_tick) begin
               cmd.advance = 1'b1;
               state_in    = S_SCAN;
            end else if (sts.out_free) begin
               cmd.exec_op = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN: begin
            if (step) begin
               cmd.scan_step = 1'b1;
               if (sts.scan_done) state_in = S_END;
            end
         end
         S_END: begin
            if (sts.out_free) begin
               cmd.emit_end = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### hw/rtl/stt_datapath.sv
// ----------------------------------------------------------------------------
// stt_datapath
// Counters, slot table, request and result registers.
// ----------------------------------------------------------------------------
module stt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  stt_pkg::cmd_type                cmd,
   output stt_pkg::sts_type                sts,
   input  logic [stt_pkg::OP_W-1:0]        req_op,
   input  logic [31:0]                     req_period_ticks,
   input  logic [stt_pkg::SLOT_W-1:0]      req_slot_index,
   input  logic [31:0]                     req_time_value,
   input  logic                            csr_valid,
   input  logic [stt_pkg::TPS_W-1:0]       csr_ticks_per_second,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [stt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [stt_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [31:0]                     rsp_tick_count,
   output logic [31:0]                     rsp_seconds,
   output logic                            rsp_last
);

   localparam int SIW = stt_pkg::SLOT_IW;

   // request beat
   logic [stt_pkg::OP_W-1:0]   op_ff;
   logic [31:0]                period_ff;
   logic [stt_pkg::SLOT_W-1:0] index_ff;
   logic [31:0]                tval_ff;

   // counters and register
   logic [31:0]                tick_ff, tick_in;
   logic [stt_pkg::TPS_W-1:0]  sub_ff, sub_in, sub_inc;
   logic [31:0]                sec_ff, sec_in;
   logic [stt_pkg::TPS_W-1:0]  tps_ff;

   // slot table
   logic [31:0]                slot_period_ff [stt_pkg::SLOTS];
   logic [31:0]                slot_last_ff   [stt_pkg::SLOTS];
   logic [stt_pkg::SLOTS-1:0]  slot_repeats_ff;
   logic [stt_pkg::SLOTS-1:0]  active_ff, active_in;
   logic [SIW-1:0]             scan_ff, scan_in;

   // result register
   logic                       rsp_valid_ff;
   logic [stt_pkg::STATUS_W-1:0] rsp_status_ff, status_in;
   logic [stt_pkg::SLOT_W-1:0] rsp_slot_ff, slot_in;
   logic [31:0]                rsp_tick_ff, rsp_sec_ff;
   logic                       rsp_last_ff, last_in;

   logic                       free_found;
   logic [SIW-1:0]             free_idx;
   logic                       is_start, cancel_ok;
   logic [31:0]                elapsed;
   logic                       fire, emit, fire_wr, start_wr;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = stt_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SIW'(i);
         end
      end
   end

   assign is_start  = (op_ff == stt_pkg::OP_START_PER) || (op_ff == stt_pkg::OP_START_ONCE);
   assign cancel_ok = ({1'b0, index_ff} < (stt_pkg::SLOT_W + 1)'(stt_pkg::SLOTS));

   // wrap-safe elapsed time of the slot under scan
   assign elapsed  = tick_ff - slot_last_ff[scan_ff];
   assign fire     = active_ff[scan_ff] && (elapsed >= slot_period_ff[scan_ff]);
   assign fire_wr  = cmd.scan_step && fire;
   assign start_wr = cmd.exec_op && is_start && free_found;
   assign emit     = cmd.exec_op || fire_wr || cmd.emit_end;

   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.is_tick   = (op_ff == stt_pkg::OP_TICK);
   assign sts.fire      = fire;
   assign sts.scan_done = (scan_ff == SIW'(stt_pkg::SLOTS - 1));

   assign sub_inc = sub_ff + 1'b1;

   always_comb begin
      tick_in   = tick_ff;
      sub_in    = sub_ff;
      sec_in    = sec_ff;
      active_in = active_ff;
      scan_in   = scan_ff;
      status_in = stt_pkg::ST_DONE;
      slot_in   = '0;
      last_in   = 1'b1;
      if (cmd.advance) begin
         tick_in = tick_ff + 1'b1;
         scan_in = '0;
         // count wraps mod 2^16, so a zero register rolls over every 65536 ticks
         if (sub_inc == tps_ff) begin
            sub_in = '0;
            sec_in = sec_ff + 1'b1;
         end else begin
            sub_in = sub_inc;
         end
      end
      if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
         if (fire) begin
            status_in = stt_pkg::ST_FIRED;
            slot_in   = stt_pkg::SLOT_W'(scan_ff);
            last_in   = 1'b0;
            if (!slot_repeats_ff[scan_ff]) active_in[scan_ff] = 1'b0;
         end
      end
      if (cmd.emit_end) status_in = stt_pkg::ST_SCAN_END;
      if (cmd.exec_op) begin
         case (op_ff)
            stt_pkg::OP_START_PER, stt_pkg::OP_START_ONCE: begin
               if (free_found) begin
                  active_in[free_idx] = 1'b1;
                  slot_in             = stt_pkg::SLOT_W'(free_idx);
               end else begin
                  status_in = stt_pkg::ST_FULL;
               end
            end
            stt_pkg::OP_CANCEL: begin
               if (cancel_ok) active_in[index_ff[SIW-1:0]] = 1'b0;
            end
            stt_pkg::OP_SET_SEC: begin
               sec_in = tval_ff;
               sub_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         period_ff <= req_period_ticks;
         index_ff  <= req_slot_index;
         tval_ff   <= req_time_value;
      end
      if (start_wr) begin
         slot_period_ff[free_idx]  <= period_ff;
         slot_last_ff[free_idx]    <= tick_ff;
         slot_repeats_ff[free_idx] <= (op_ff == stt_pkg::OP_START_PER);
      end
      if (fire_wr) slot_last_ff[scan_ff] <= tick_ff;
      if (emit) begin
         rsp_status_ff <= status_in;
         rsp_slot_ff   <= slot_in;
         rsp_tick_ff   <= tick_in;
         rsp_sec_ff    <= sec_in;
         rsp_last_ff   <= last_in;
      end
      scan_ff <= scan_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         sub_ff       <= '0;
         sec_ff       <= '0;
         tps_ff       <= stt_pkg::TPS_RESET;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff   <= tick_in;
         sub_ff    <= sub_in;
         sec_ff    <= sec_in;
         active_ff <= active_in;
         if (csr_valid) tps_ff <= csr_ticks_per_second;
         if (emit)           rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_tick_count = rsp_tick_ff;
   assign rsp_seconds    = rsp_sec_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### hw/rtl/software_timer_slot_table_top.sv
// ----------------------------------------------------------------------------
// software_timer_slot_table_top
// Tick counter, seconds clock and a table of 16 software timer slots.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per operation (tick, start periodic, start one-shot,
//            cancel, set seconds). Taken only while the block is idle.
//   rsp_*  : result beats; rsp_last marks the final beat of an operation.
//            A tick gives one beat per fired slot, then a scan-end beat.
//   csr_*  : ticks_per_second write port, always ready; write while idle.
// Sequence:
//   Non-tick ops: the request beat is captured, then the op runs and its
//   result is registered once the output register has room; the next
//   request is taken the cycle after that.
//   Tick: the request beat, then a step that advances the counters, then a
//   scan of the slots (one compare of the elapsed time per cycle while no
//   firing slot waits for the output register), then the end beat.
// Reset: counters and seconds clear, every slot free, ticks_per_second 1000.
// Stall: a single output register holds a result; while it is not taken
//   the scan stops on the next firing slot and resumes when room appears.
// ----------------------------------------------------------------------------
module software_timer_slot_table_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [stt_pkg::OP_W-1:0]        req_op,
   input  logic [31:0]                     req_period_ticks,
   input  logic [stt_pkg::SLOT_W-1:0]      req_slot_index,
   input  logic [31:0]                     req_time_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [stt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [stt_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [31:0]                     rsp_tick_count,
   output logic [31:0]                     rsp_seconds,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stt_pkg::TPS_W-1:0]       csr_ticks_per_second
);

   stt_pkg::cmd_type cmd;
   stt_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stt_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_op               (req_op),
      .req_period_ticks     (req_period_ticks),
      .req_slot_index       (req_slot_index),
      .req_time_value       (req_time_value),
      .csr_valid            (csr_valid),
      .csr_ticks_per_second (csr_ticks_per_second),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_slot             (rsp_slot),
      .rsp_tick_count       (rsp_tick_count),
      .rsp_seconds          (rsp_seconds),
      .rsp_last             (rsp_last)
   );

endmodule

### tb/sv/software_timer_slot_table_top_tb.sv
// ----------------------------------------------------------------------------
// software_timer_slot_table_top_tb
// Self-checking bench for the timer slot table. A shadow copy of the counters,
// seconds clock and slot table predicts every result beat of each accepted
// request; result beats are compared in order. Directed requests cover the
// corner cases, then random traffic runs under several ticks_per_second
// settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module software_timer_slot_table_top_tb;

   localparam logic [stt_pkg::OP_W-1:0] OP_RESERVED_LO = 3'd5;
   localparam logic [stt_pkg::OP_W-1:0] OP_RESERVED_HI = 3'd7;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 2 * stt_pkg::SLOTS + 8;   // one full scan plus slack
   localparam int LONG_HOLD       = 300;
   localparam int ITEMS_PER_PHASE = 14;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [stt_pkg::OP_W-1:0]   op;
      logic [31:0]                period_ticks;
      logic [stt_pkg::SLOT_W-1:0] slot_index;
      logic [31:0]                time_value;
   } timer_request_type;

   typedef struct packed {
      logic [stt_pkg::STATUS_W-1:0] status;
      logic [stt_pkg::SLOT_W-1:0]   slot;
      logic [31:0]                  tick_count;
      logic [31:0]                  seconds;
      logic                         last;
   } timer_result_type;

   // Shadow of the block state; queues the result beats each request causes.
   class slot_table_shadow;
      logic [31:0]               tick_counter;
      logic [15:0]               subsecond_count;
      logic [31:0]               seconds_clock;
      logic [stt_pkg::TPS_W-1:0] ticks_per_second;
      logic [31:0]               period [stt_pkg::SLOTS];
      logic [31:0]               last_fired [stt_pkg::SLOTS];
      bit                        repeats [stt_pkg::SLOTS];
      bit                        active [stt_pkg::SLOTS];
      timer_result_type          pending_results [$];
      int unsigned               mismatch_count;

      function new();
         tick_counter     = '0;
         subsecond_count  = '0;
         seconds_clock    = '0;
         ticks_per_second = stt_pkg::TPS_RESET;
         mismatch_count   = 0;
         foreach (active[i]) active[i] = 1'b0;
      endfunction

      function void set_ticks_per_second(logic [stt_pkg::TPS_W-1:0] value);
         ticks_per_second = value;
      endfunction

      function void push_result(logic [stt_pkg::STATUS_W-1:0] status, int slot, logic last);
         timer_result_type r;
         r.status     = status;
         r.slot       = stt_pkg::SLOT_W'(slot);
         r.tick_count = tick_counter;
         r.seconds    = seconds_clock;
         r.last       = last;
         pending_results.push_back(r);
      endfunction

      function void claim_slot(logic [31:0] period_ticks, bit periodic);
         int found;
         found = -1;
         for (int i = 0; i < stt_pkg::SLOTS && found < 0; i++)
            if (!active[i]) found = i;
         if (found < 0) begin
            push_result(stt_pkg::ST_FULL, 0, 1'b1);
         end else begin
            period[found]     = period_ticks;
            last_fired[found] = tick_counter;
            repeats[found]    = periodic;
            active[found]     = 1'b1;
            push_result(stt_pkg::ST_DONE, found, 1'b1);
         end
      endfunction

      function void note_request(timer_request_type rq);
         logic [31:0] elapsed;
         case (rq.op)
            stt_pkg::OP_TICK: begin
               tick_counter    = tick_counter + 32'd1;
               subsecond_count = subsecond_count + 16'd1;
               // zero setting rolls over only when the count wraps to zero
               if (subsecond_count == ticks_per_second) begin
                  subsecond_count = '0;
                  seconds_clock   = seconds_clock + 32'd1;
               end
               for (int i = 0; i < stt_pkg::SLOTS; i++) begin
                  elapsed = tick_counter - last_fired[i];
                  if (active[i] && elapsed >= period[i]) begin
                     last_fired[i] = tick_counter;
                     if (!repeats[i]) active[i] = 1'b0;
                     push_result(stt_pkg::ST_FIRED, i, 1'b0);
                  end
               end
               push_result(stt_pkg::ST_SCAN_END, 0, 1'b1);
            end
            stt_pkg::OP_START_PER:  claim_slot(rq.period_ticks, 1'b1);
            stt_pkg::OP_START_ONCE: claim_slot(rq.period_ticks, 1'b0);
            stt_pkg::OP_CANCEL: begin
               if (rq.slot_index < stt_pkg::SLOTS) active[rq.slot_index] = 1'b0;
               push_result(stt_pkg::ST_DONE, 0, 1'b1);
            end
            stt_pkg::OP_SET_SEC: begin
               seconds_clock   = rq.time_value;
               subsecond_count = '0;
               push_result(stt_pkg::ST_DONE, 0, 1'b1);
            end
            default: push_result(stt_pkg::ST_DONE, 0, 1'b1);
         endcase
      endfunction

      function void report(string what, timer_result_type want, timer_result_type got);
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display({"%s: expected st %0d slot %0d tick %0d sec %0d last %0d,",
                      " got st %0d slot %0d tick %0d sec %0d last %0d"},
                     what, want.status, want.slot, want.tick_count, want.seconds,
                     want.last, got.status, got.slot, got.tick_count, got.seconds,
                     got.last);
      endfunction

      function void check_result(timer_result_type got);
         timer_result_type want;
         if (pending_results.size() == 0) begin
            report("unexpected result beat", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.tick_count !== want.tick_count || got.seconds !== want.seconds ||
                got.last !== want.last)
               report("result mismatch", want, got);
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [stt_pkg::OP_W-1:0]     req_op = stt_pkg::OP_TICK;
   logic [31:0]                  req_period_ticks = '0;
   logic [stt_pkg::SLOT_W-1:0]   req_slot_index = '0;
   logic [31:0]                  req_time_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [stt_pkg::STATUS_W-1:0] rsp_status;
   logic [stt_pkg::SLOT_W-1:0]   rsp_slot;
   logic [31:0]                  rsp_tick_count;
   logic [31:0]                  rsp_seconds;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [stt_pkg::TPS_W-1:0]    csr_ticks_per_second = '0;

   bit                        rsp_hold_request = 1'b0;
   logic [stt_pkg::TPS_W-1:0] random_phase_tps [5] = '{16'd3, 16'hFFFF, 16'd0, 16'd1, 16'd5};
   slot_table_shadow          shadow = new();

   software_timer_slot_table_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_period_ticks     (req_period_ticks),
      .req_slot_index       (req_slot_index),
      .req_time_value       (req_time_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_slot             (rsp_slot),
      .rsp_tick_count       (rsp_tick_count),
      .rsp_seconds          (rsp_seconds),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_ticks_per_second (csr_ticks_per_second)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic timer_request_type random_request();
      timer_request_type rq;
      int unsigned       pick;
      rq.period_ticks = $urandom;
      rq.slot_index   = stt_pkg::SLOT_W'($urandom_range(0, 63));
      rq.time_value   = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 40)      rq.op = stt_pkg::OP_TICK;
      else if (pick < 55) rq.op = stt_pkg::OP_START_PER;
      else if (pick < 68) rq.op = stt_pkg::OP_START_ONCE;
      else if (pick < 85) rq.op = stt_pkg::OP_CANCEL;
      else if (pick < 92) rq.op = stt_pkg::OP_SET_SEC;
      else rq.op = stt_pkg::OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      // short periods so slots actually fire; a few near the top of the range
      pick = $urandom_range(0, 9);
      if (pick < 7)       rq.period_ticks = $urandom_range(0, 6);
      else if (pick == 9) rq.period_ticks = 32'hFFFF_FFFF - $urandom_range(0, 3);
      if (rq.op == stt_pkg::OP_CANCEL && $urandom_range(0, 4) != 0)
         rq.slot_index = stt_pkg::SLOT_W'($urandom_range(0, stt_pkg::SLOTS - 1));
      if (rq.op == stt_pkg::OP_SET_SEC && $urandom_range(0, 3) == 0)
         rq.time_value = 32'hFFFF_FFFF - $urandom_range(0, 2);
      return rq;
   endfunction

   // Called right after a posedge; valid stays high between back-to-back beats.
   task automatic send_request(timer_request_type rq, int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_op           <= rq.op;
      req_period_ticks <= rq.period_ticks;
      req_slot_index   <= rq.slot_index;
      req_time_value   <= rq.time_value;
      do @(posedge clock); while (!req_ready);
      shadow.note_request(rq);
   endtask

   task automatic send_op(logic [stt_pkg::OP_W-1:0] op, logic [31:0] arg);
      timer_request_type rq;
      rq.op           = op;
      rq.period_ticks = $urandom;
      rq.slot_index   = stt_pkg::SLOT_W'($urandom_range(0, 63));
      rq.time_value   = $urandom;
      case (op)
         stt_pkg::OP_START_PER, stt_pkg::OP_START_ONCE: rq.period_ticks = arg;
         stt_pkg::OP_CANCEL:  rq.slot_index = stt_pkg::SLOT_W'(arg);
         stt_pkg::OP_SET_SEC: rq.time_value = arg;
         default: ;
      endcase
      send_request(rq, pick_gap());
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (shadow.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ticks_per_second(logic [stt_pkg::TPS_W-1:0] value);
      @(negedge clock);
      csr_valid            <= 1'b1;
      csr_ticks_per_second <= value;
      do @(posedge clock); while (!csr_ready);
      shadow.set_ticks_per_second(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         shadow.check_result(timer_result_type'({rsp_status, rsp_slot,
                                                 rsp_tick_count, rsp_seconds,
                                                 rsp_last}));
   end

   // Result side: ready runs and gaps, plus one long hold-off on request.
   initial begin
      int unsigned hold;
      int unsigned run;
      int unsigned low;
      hold = 0;
      run  = 0;
      low  = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            hold = LONG_HOLD;
            rsp_hold_request = 1'b0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (run > 0) begin
            rsp_ready <= 1'b1;
            run--;
         end else if (low > 0) begin
            rsp_ready <= 1'b0;
            low--;
         end else begin
            run = $urandom_range(0, 40);
            low = pick_gap();
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("software_timer_slot_table_top_tb: FAIL");
      $finish;
   end

   initial begin
      int unsigned k;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, then slots with zero, maximum and small periods
      send_op(stt_pkg::OP_TICK, 0);
      send_op(stt_pkg::OP_START_PER, 32'd0);
      send_op(stt_pkg::OP_START_ONCE, 32'hFFFF_FFFF);
      send_op(stt_pkg::OP_START_PER, 32'd2);
      send_op(stt_pkg::OP_START_ONCE, 32'd1);
      repeat (2) send_op(stt_pkg::OP_TICK, 0);
      // out of range, just past the table, active slot, then the same slot freed
      send_op(stt_pkg::OP_CANCEL, 63);
      send_op(stt_pkg::OP_CANCEL, stt_pkg::SLOTS);
      send_op(stt_pkg::OP_CANCEL, 1);
      send_op(stt_pkg::OP_CANCEL, 1);
      send_op(OP_RESERVED_LO, 0);
      send_op(stt_pkg::OP_W'(OP_RESERVED_LO + 3'd1), 0);
      send_op(OP_RESERVED_HI, 0);
      // fill the table with zero periods until it reports full, then all slots but slot 2 fire
      for (k = 0; k < stt_pkg::SLOTS - 1; k++)
         send_op((k % 2 == 1) ? stt_pkg::OP_START_ONCE : stt_pkg::OP_START_PER, 32'd0);
      send_op(stt_pkg::OP_TICK, 0);

      // one tick per second, seconds clock wraps
      wait_for_idle();
      write_ticks_per_second(16'd1);
      send_op(stt_pkg::OP_SET_SEC, 32'hFFFF_FFFF);
      repeat (2) send_op(stt_pkg::OP_TICK, 0);

      // count left above a lowered setting keeps running
      wait_for_idle();
      write_ticks_per_second(16'd6);
      send_op(stt_pkg::OP_SET_SEC, 32'd5);
      repeat (4) send_op(stt_pkg::OP_TICK, 0);
      wait_for_idle();
      write_ticks_per_second(16'd2);
      repeat (2) send_op(stt_pkg::OP_TICK, 0);

      foreach (random_phase_tps[ph]) begin
         wait_for_idle();
         write_ticks_per_second(random_phase_tps[ph]);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (ph == 1 && k == 6) rsp_hold_request = 1'b1;
            if (ph == 2 && k == 11) wait_for_idle();
            send_request(random_request(), (k < 8) ? 0 : pick_gap());
         end
      end

      wait_for_idle();
      shadow.mismatch_count += shadow.pending_results.size();
      if (shadow.mismatch_count == 0)
         $display("software_timer_slot_table_top_tb: PASS");
      else
         $display("software_timer_slot_table_top_tb: FAIL");
      $finish;
   end

endmodule

### sim.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_ctrl.sv
hw/rtl/stt_datapath.sv
hw/rtl/software_timer_slot_table_top.sv
tb/sv/software_timer_slot_table_top_tb.sv
